### rtl/rarmt_pkg.sv
// Shared types, codes and saturating arithmetic for the range-add / range-min tree.
`default_nettype none
package rarmt_pkg;

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_ADD   = 2'd1;
   localparam logic [1:0] MODE_INCR  = 2'd2;
   localparam logic [1:0] MODE_QUERY = 2'd3;

   localparam logic signed [47:0] VAL_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] VAL_MIN = 48'sh8000_0000_0000;
   localparam logic signed [47:0] VAL_ONE = 48'sd1;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_CLEAR,
      CMD_LOAD,
      CMD_START,
      CMD_READ,
      CMD_EVAL,
      CMD_CH1_RD,
      CMD_CH2_RD,
      CMD_CH2_WR,
      CMD_DESCEND,
      CMD_RETURN,
      CMD_OUT
   } cmd_type;

   typedef struct packed {
      logic       clear_last;
      logic [1:0] mode;
      logic       empty;
      logic       point_ok;
      logic       need_child;
      logic       partial;
      logic       partial_ff;
      logic       sp_zero;
      logic       top_phase;
   } status_type;

   function automatic logic signed [47:0] sat_add(input logic signed [47:0] a,
                                                   input logic signed [47:0] b);
      logic signed [48:0] s;
      s = {a[47], a} + {b[47], b};
      if (s[48] != s[47]) begin
         sat_add = s[48] ? VAL_MIN : VAL_MAX;
      end else begin
         sat_add = s[47:0];
      end
   endfunction

endpackage
`default_nettype wire

### rtl/rarmt_ctrl.sv
// Sequencer for tree clearing, node visits, child pushes and stack unwinding.
`default_nettype none
module rarmt_ctrl
   import rarmt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type st,
   output cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_PREP, ST_READ, ST_EVAL, ST_CH1, ST_CH2, ST_CH2W,
      ST_DESCEND, ST_RETURN, ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = CMD_NONE;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      case (state_ff)
         ST_CLEAR: begin
            cmd = CMD_CLEAR;
            if (st.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd      = CMD_LOAD;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (st.mode == MODE_QUERY) begin
               if (st.empty) begin
                  state_in = ST_DONE;
               end else begin
                  cmd      = CMD_START;
                  state_in = ST_READ;
               end
            end else if ((st.mode == MODE_ADD) ? !st.empty : st.point_ok) begin
               cmd      = CMD_START;
               state_in = ST_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            cmd      = CMD_READ;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd = CMD_EVAL;
            if (st.need_child)   state_in = ST_CH1;
            else if (st.partial) state_in = ST_DESCEND;
            else                 state_in = ST_RETURN;
         end
         ST_CH1: begin
            cmd      = CMD_CH1_RD;
            state_in = ST_CH2;
         end
         ST_CH2: begin
            cmd      = CMD_CH2_RD;
            state_in = ST_CH2W;
         end
         ST_CH2W: begin
            cmd      = CMD_CH2_WR;
            state_in = st.partial_ff ? ST_DESCEND : ST_RETURN;
         end
         ST_DESCEND: begin
            cmd      = CMD_DESCEND;
            state_in = ST_READ;
         end
         ST_RETURN: begin
            if (st.sp_zero) begin
               state_in = (st.mode == MODE_QUERY) ? ST_DONE : ST_IDLE;
            end else begin
               cmd = CMD_RETURN;
               // left child done: go visit the right one
               if (!st.top_phase) state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd          = CMD_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_out_only_query: assert property (@(posedge clock) disable iff (reset)
      cmd == CMD_OUT |-> st.mode == MODE_QUERY)
      else $error("result issued for a non-query item");
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_ready)
      else $error("item accepted during clear pass");
   a_return_stack: assert property (@(posedge clock) disable iff (reset)
      cmd == CMD_RETURN |-> !st.sp_zero)
      else $error("stack pop with empty stack");

endmodule
`default_nettype wire

### rtl/rarmt_dpath.sv
// Tree memories, traversal stack, saturating update logic and result register.
`default_nettype none
module rarmt_dpath
   import rarmt_pkg::*;
#(
   parameter int MAX_ELEMS = 1024
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   output status_type              st,
   input  wire logic               csr_wr_en,
   input  wire logic [10:0]        csr_wr_data,
   input  wire logic [1:0]         req_mode,
   input  wire logic [9:0]         req_index_low,
   input  wire logic [9:0]         req_index_high,
   input  wire logic signed [47:0] req_value,
   output logic signed [47:0]      rsp_min_value,
   output logic                    rsp_empty_range
);

   localparam int IW    = $clog2(MAX_ELEMS);
   localparam int CW    = ((IW > 11) ? IW : 11) + 1;
   localparam int NODES = 4 * MAX_ELEMS;
   localparam int NW    = $clog2(NODES);
   localparam int SD    = IW + 1;
   localparam int SIW   = $clog2(SD);
   localparam int SPW   = $clog2(SD + 1);

   logic signed [47:0] nm_mem [NODES];
   logic signed [47:0] pd_mem [NODES];
   logic signed [47:0] nm_q_ff, pd_q_ff;
   logic               nm_we, pd_we, nm_re, pd_re;
   logic [NW-1:0]      nm_wa, pd_wa, pd_ra;
   logic signed [47:0] nm_wd, pd_wd;

   logic [10:0]        elems_ff;
   logic [NW-1:0]      clr_ff;
   logic [1:0]         mode_ff;
   logic [CW-1:0]      lo_ff, hi_ff;
   logic               empty_ff, point_ok_ff;
   logic signed [47:0] val_ff;

   logic [NW-1:0]      cur_node_ff;
   logic [IW-1:0]      cur_l_ff, cur_r_ff;
   logic signed [47:0] ret_ff, padd_ff;
   logic               dfull_ff, partial_ff;

   logic [NW-1:0]      fr_node [SD];
   logic [IW-1:0]      fr_l    [SD];
   logic [IW-1:0]      fr_r    [SD];
   logic               fr_ph   [SD];
   logic signed [47:0] fr_acc  [SD];
   logic [SPW-1:0]     sp_ff;
   logic [SIW-1:0]     top;

   // request decode
   logic [CW-1:0] limit, lim_m1, lo_e, hi_e, hi_c;
   logic          req_empty, req_pt_ok;

   always_comb begin
      limit = CW'(elems_ff);
      if (CW'(elems_ff) > CW'(MAX_ELEMS)) limit = CW'(MAX_ELEMS);
      lim_m1 = limit - 1'b1;
      lo_e   = CW'(req_index_low);
      hi_e   = CW'(req_index_high);
      hi_c   = ((limit != '0) && (hi_e > lim_m1)) ? lim_m1 : hi_e;
      req_empty = (limit == '0) || (lo_e >= limit) || (lo_e > hi_c);
      req_pt_ok = (limit != '0) && (lo_e < limit);
   end

   // node evaluation
   logic [CW-1:0]      l_e, r_e;
   logic               leaf, outside, full;
   logic signed [47:0] settled, fin, ch_upd1, ch_upd;
   logic [IW:0]        mid_sum;
   logic [IW-1:0]      mid;
   logic [NW-1:0]      c1, c2;

   always_comb begin
      l_e     = CW'(cur_l_ff);
      r_e     = CW'(cur_r_ff);
      leaf    = (cur_l_ff == cur_r_ff);
      outside = (hi_ff < l_e) || (lo_ff > r_e);
      full    = (lo_ff <= l_e) && (r_e <= hi_ff);
      settled = sat_add(nm_q_ff, pd_q_ff);
      case (mode_ff)
         MODE_LOAD: fin = val_ff;
         MODE_ADD:  fin = sat_add(settled, val_ff);
         MODE_INCR: fin = sat_add(settled, VAL_ONE);
         default:   fin = settled;
      endcase
      mid_sum = {1'b0, cur_l_ff} + {1'b0, cur_r_ff};
      mid     = mid_sum[IW:1];
      c1      = NW'({cur_node_ff, 1'b0} + 1'b1);
      c2      = NW'({cur_node_ff, 1'b0} + 2'd2);
      ch_upd1 = sat_add(pd_q_ff, padd_ff);
      ch_upd  = dfull_ff ? sat_add(ch_upd1, val_ff) : ch_upd1;
   end

   // stack top
   logic signed [47:0] ret_min;
   logic [IW:0]        tmid_sum;
   logic [IW-1:0]      tmid;

   always_comb begin
      top      = SIW'(sp_ff - 1'b1);
      ret_min  = (fr_acc[top] < ret_ff) ? fr_acc[top] : ret_ff;
      tmid_sum = {1'b0, fr_l[top]} + {1'b0, fr_r[top]};
      tmid     = tmid_sum[IW:1];
   end

   // memory port steering
   always_comb begin
      nm_we = 1'b0; nm_wa = cur_node_ff; nm_wd = settled;
      pd_we = 1'b0; pd_wa = cur_node_ff; pd_wd = '0;
      nm_re = 1'b0; pd_re = 1'b0;        pd_ra = cur_node_ff;
      case (cmd)
         CMD_CLEAR: begin
            nm_we = 1'b1; nm_wa = clr_ff; nm_wd = '0;
            pd_we = 1'b1; pd_wa = clr_ff;
         end
         CMD_READ: begin
            nm_re = 1'b1; pd_re = 1'b1;
         end
         CMD_EVAL: begin
            nm_we = 1'b1;
            nm_wd = (!outside && full) ? fin : settled;
            pd_we = 1'b1;
         end
         CMD_CH1_RD: begin
            pd_re = 1'b1; pd_ra = c1;
         end
         CMD_CH2_RD: begin
            pd_re = 1'b1; pd_ra = c2;
            pd_we = 1'b1; pd_wa = c1; pd_wd = ch_upd;
         end
         CMD_CH2_WR: begin
            pd_we = 1'b1; pd_wa = c2; pd_wd = ch_upd;
         end
         CMD_RETURN: begin
            // pull-up on updates only; a query leaves inner nodes as settled
            if (fr_ph[top] && (mode_ff != MODE_QUERY)) begin
               nm_we = 1'b1; nm_wa = fr_node[top]; nm_wd = ret_min;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (nm_we) nm_mem[nm_wa] <= nm_wd;
      if (nm_re) nm_q_ff <= nm_mem[cur_node_ff];
   end

   always_ff @(posedge clock) begin
      if (pd_we) pd_mem[pd_wa] <= pd_wd;
      if (pd_re) pd_q_ff <= pd_mem[pd_ra];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         elems_ff <= 11'd1024;
         clr_ff   <= '0;
         sp_ff    <= '0;
      end else begin
         if (csr_wr_en) elems_ff <= csr_wr_data;
         if (cmd == CMD_CLEAR) clr_ff <= clr_ff + 1'b1;
         case (cmd)
            CMD_START:   sp_ff <= '0;
            CMD_DESCEND: sp_ff <= sp_ff + 1'b1;
            CMD_RETURN:  if (fr_ph[top]) sp_ff <= sp_ff - 1'b1;
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      case (cmd)
         CMD_LOAD: begin
            mode_ff     <= req_mode;
            val_ff      <= req_value;
            empty_ff    <= req_empty;
            point_ok_ff <= req_pt_ok;
            lo_ff       <= lo_e;
            hi_ff       <= ((req_mode == MODE_ADD) || (req_mode == MODE_QUERY)) ? hi_c : lo_e;
         end
         CMD_START: begin
            cur_node_ff <= '0;
            cur_l_ff    <= '0;
            cur_r_ff    <= IW'(MAX_ELEMS - 1);
         end
         CMD_EVAL: begin
            padd_ff    <= pd_q_ff;
            dfull_ff   <= full && !leaf && (mode_ff == MODE_ADD);
            partial_ff <= !outside && !full;
            if (outside) ret_ff <= (mode_ff == MODE_QUERY) ? VAL_MAX : settled;
            else         ret_ff <= fin;
         end
         CMD_DESCEND: begin
            fr_node[SIW'(sp_ff)] <= cur_node_ff;
            fr_l[SIW'(sp_ff)]    <= cur_l_ff;
            fr_r[SIW'(sp_ff)]    <= cur_r_ff;
            fr_ph[SIW'(sp_ff)]   <= 1'b0;
            cur_node_ff          <= c1;
            cur_r_ff             <= mid;
         end
         CMD_RETURN: begin
            if (!fr_ph[top]) begin
               fr_acc[top] <= ret_ff;
               fr_ph[top]  <= 1'b1;
               cur_node_ff <= NW'({fr_node[top], 1'b0} + 2'd2);
               cur_l_ff    <= tmid + 1'b1;
               cur_r_ff    <= fr_r[top];
            end else begin
               ret_ff <= ret_min;
            end
         end
         CMD_OUT: begin
            rsp_min_value   <= empty_ff ? VAL_MAX : ret_ff;
            rsp_empty_range <= empty_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      st.clear_last = (clr_ff == NW'(NODES - 1));
      st.mode       = mode_ff;
      st.empty      = empty_ff;
      st.point_ok   = point_ok_ff;
      st.need_child = !leaf && ((pd_q_ff != '0) || (full && (mode_ff == MODE_ADD)));
      st.partial    = !outside && !full;
      st.partial_ff = partial_ff;
      st.sp_zero    = (sp_ff == '0);
      st.top_phase  = fr_ph[top];
   end

   a_stack_depth: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SPW'(SD))
      else $error("traversal stack overflow");
   a_partial_inner: assert property (@(posedge clock) disable iff (reset)
      (cmd == CMD_EVAL) && st.partial |-> !leaf)
      else $error("leaf seen as partially covered");
   a_push_depth: assert property (@(posedge clock) disable iff (reset)
      cmd == CMD_DESCEND |-> sp_ff < SPW'(SD))
      else $error("push past stack depth");

endmodule
`default_nettype wire

### rtl/range_add_range_min_tree_unit.sv
// Top level of the range-add / range-min lazy tree unit.
//
//   channel   ports                                        role
//   req       req_valid/ready, mode, index_low/high, value   one operation item
//   rsp       rsp_valid/ready, min_value, empty_range         query result item
//   csr       csr_wr_en, csr_wr_data                          elems_in_use write
//
// Each visited node is read, evaluated and stepped from; a pending add pushed to
// both children first reads and writes each one through the single pending-memory
// port. A range item visits up to about four nodes per level, log2(MAX_ELEMS)+1
// levels, with a return step per stack pop; a point item one path plus siblings.
// After reset a clearing pass zeros all 4*MAX_ELEMS words of both memories, taking
// no item. A waiting result stalls only the next query's finish.
`default_nettype none
module range_add_range_min_tree_unit
   import rarmt_pkg::*;
#(
   parameter int MAX_ELEMS = 1024
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_mode,
   input  wire logic [9:0]         req_index_low,
   input  wire logic [9:0]         req_index_high,
   input  wire logic signed [47:0] req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [47:0]      rsp_min_value,
   output logic                    rsp_empty_range,
   input  wire logic               csr_wr_en,
   input  wire logic [10:0]        csr_wr_data
);

   cmd_type    cmd;
   status_type st;

   rarmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .st        (st),
      .cmd       (cmd)
   );

   rarmt_dpath #(.MAX_ELEMS(MAX_ELEMS)) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .st              (st),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_mode        (req_mode),
      .req_index_low   (req_index_low),
      .req_index_high  (req_index_high),
      .req_value       (req_value),
      .rsp_min_value   (rsp_min_value),
      .rsp_empty_range (rsp_empty_range)
   );

endmodule
`default_nettype wire

### test/range_add_range_min_tree_unit_tb.sv
// Testbench for the range-add / range-min tree unit against a lazy-tree predictor.
`timescale 1ns / 1ps
module range_add_range_min_tree_unit_tb;
   import rarmt_pkg::*;

   localparam int ELEMS      = 1024;
   localparam int NODES      = 4 * ELEMS;
   localparam int SETTLE_CYC = 3000;
   localparam int HOLD_CYC   = 2500;
   localparam longint CYCLE_LIMIT = 3000000;
   localparam longint SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint SAT_LO = -SAT_HI - 1;

   typedef struct {
      logic [1:0]         mode;
      logic [9:0]         lo;
      logic [9:0]         hi;
      logic signed [47:0] value;
   } op_item_type;

   typedef struct {
      longint min_value;
      bit     empty;
   } min_result_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_mode = MODE_LOAD;
   logic [9:0]         req_index_low = '0;
   logic [9:0]         req_index_high = '0;
   logic signed [47:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [47:0] rsp_min_value;
   logic               rsp_empty_range;
   logic               csr_wr_en = 1'b0;
   logic [10:0]        csr_wr_data = '0;

   op_item_type    op_queue[$];
   min_result_type min_queue[$];
   longint      node_min[NODES];
   longint      node_pend[NODES];
   int          elems_cfg = ELEMS;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          hold_req = 1'b0;
   int          hold_left = 0;
   int          errors = 0;
   int          ops_done = 0;
   int          mins_seen = 0;
   int          cfg_count = 0;
   longint      cycles = 0;

   range_add_range_min_tree_unit #(.MAX_ELEMS(ELEMS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_index_low(req_index_low), .req_index_high(req_index_high),
      .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_min_value(rsp_min_value),
      .rsp_empty_range(rsp_empty_range),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // ---- lazy min tree predictor ----
   function automatic longint clamp_add(longint a, longint b);
      longint s;
      s = a + b;
      if (s > SAT_HI) return SAT_HI;
      if (s < SAT_LO) return SAT_LO;
      return s;
   endfunction

   function automatic void pass_down(int n, longint d);
      if (2 * n + 1 < NODES) node_pend[2 * n + 1] = clamp_add(node_pend[2 * n + 1], d);
      if (2 * n + 2 < NODES) node_pend[2 * n + 2] = clamp_add(node_pend[2 * n + 2], d);
   endfunction

   function automatic void flush_node(int n, bit leaf);
      longint p;
      p = node_pend[n];
      if (p != 0) begin
         node_min[n] = clamp_add(node_min[n], p);
         if (!leaf) pass_down(n, p);
         node_pend[n] = 0;
      end
   endfunction

   function automatic void refresh_node(int n);
      if (2 * n + 2 < NODES) begin
         node_min[n] = (node_min[2 * n + 1] < node_min[2 * n + 2]) ?
                       node_min[2 * n + 1] : node_min[2 * n + 2];
      end
   endfunction

   function automatic void span_add(int n, int l, int r, int lo, int hi, longint d);
      int mid;
      if (n >= NODES) return;
      flush_node(n, l == r);
      if (hi < l || lo > r) return;
      if (lo <= l && r <= hi) begin
         node_min[n] = clamp_add(node_min[n], d);
         if (l != r) pass_down(n, d);
         return;
      end
      mid = l + (r - l) / 2;
      span_add(2 * n + 1, l, mid, lo, hi, d);
      span_add(2 * n + 2, mid + 1, r, lo, hi, d);
      refresh_node(n);
   endfunction

   function automatic void point_write(int n, int l, int r, int pos, bit load, longint v);
      int mid;
      if (n >= NODES) return;
      flush_node(n, l == r);
      if (pos < l || pos > r) return;
      if (l == r) begin
         node_min[n] = load ? v : clamp_add(node_min[n], 1);
         return;
      end
      mid = l + (r - l) / 2;
      point_write(2 * n + 1, l, mid, pos, load, v);
      point_write(2 * n + 2, mid + 1, r, pos, load, v);
      refresh_node(n);
   endfunction

   function automatic longint span_min(int n, int l, int r, int lo, int hi);
      int mid;
      longint a, b;
      if (n >= NODES) return SAT_HI;
      flush_node(n, l == r);
      if (hi < l || lo > r) return SAT_HI;
      if (lo <= l && r <= hi) return node_min[n];
      mid = l + (r - l) / 2;
      a = span_min(2 * n + 1, l, mid, lo, hi);
      b = span_min(2 * n + 2, mid + 1, r, lo, hi);
      return (a < b) ? a : b;
   endfunction

   function automatic void apply_op(op_item_type it);
      int lim, lo, hi;
      bit empty;
      min_result_type res;
      lim = (elems_cfg < ELEMS) ? elems_cfg : ELEMS;
      lo = it.lo;
      hi = it.hi;
      if (lim > 0 && hi > lim - 1) hi = lim - 1;
      empty = (lim == 0) || (lo >= lim) || (lo > hi);
      case (it.mode)
         MODE_LOAD, MODE_INCR: begin
            if (lim > 0 && lo < lim)
               point_write(0, 0, ELEMS - 1, lo, it.mode == MODE_LOAD, longint'(it.value));
         end
         MODE_ADD: begin
            if (!empty) span_add(0, 0, ELEMS - 1, lo, hi, longint'(it.value));
         end
         default: begin
            res.empty = empty;
            res.min_value = empty ? SAT_HI : span_min(0, 0, ELEMS - 1, lo, hi);
            min_queue.push_back(res);
         end
      endcase
   endfunction

   // ---- driver: feeds items from op_queue, predicts on acceptance ----
   always @(posedge clock) begin
      op_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            it.mode = req_mode;
            it.lo = req_index_low;
            it.hi = req_index_high;
            it.value = req_value;
            apply_op(it);
            ops_done++;
         end
         if (!req_valid || req_ready) begin
            if (op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               it = op_queue.pop_front();
               req_valid <= 1'b1;
               req_mode <= it.mode;
               req_index_low <= it.lo;
               req_index_high <= it.hi;
               req_value <= it.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_req) begin
         hold_left <= HOLD_CYC;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // ---- monitor ----
   always @(posedge clock) begin
      min_result_type want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("TEST FAILED");
         $finish;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
         if (rsp_valid && rsp_ready) begin
            mins_seen++;
            if (min_queue.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result item: min %0d empty %0b",
                                          rsp_min_value, rsp_empty_range);
            end else begin
               want = min_queue.pop_front();
               if (longint'(rsp_min_value) != want.min_value ||
                   rsp_empty_range != want.empty) begin
                  errors++;
                  if (errors <= 10)
                     $display("result %0d: expected min %0d empty %0b, got min %0d empty %0b",
                              mins_seen, want.min_value, want.empty,
                              rsp_min_value, rsp_empty_range);
               end
            end
         end
      end
   end

   // ---- stimulus ----
   task automatic add_op(logic [1:0] m, int lo, int hi, longint v);
      op_item_type it;
      it.mode = m;
      it.lo = lo[9:0];
      it.hi = hi[9:0];
      it.value = v[47:0];
      op_queue.push_back(it);
   endtask

   task automatic add_random(int n);
      int lim, lo, hi, r;
      longint v;
      lim = (elems_cfg < ELEMS) ? elems_cfg : ELEMS;
      repeat (n) begin
         if ($urandom_range(99) < 85) begin
            lo = $urandom_range(lim - 1);
            hi = ($urandom_range(1) != 0) ? lo + $urandom_range(15) : $urandom_range(lim - 1);
            if (hi > 1023) hi = 1023;
         end else begin
            lo = $urandom_range(1023);
            hi = $urandom_range(1023);
         end
         r = $urandom_range(99);
         if (r < 60) v = longint'($urandom_range(2000)) - 1000;
         else if (r < 85) v = longint'(int'($urandom()));
         else if (r < 93) v = {$urandom(), $urandom()};
         else v = ($urandom_range(1) != 0) ? SAT_HI : SAT_LO;
         add_op(2'($urandom_range(3)), lo, hi, v);
      end
   endtask

   task automatic drain;
      while (op_queue.size() != 0 || req_valid || min_queue.size() != 0) @(posedge clock);
      // non-query items may still be in flight
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic set_limit(int n);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= n[10:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      elems_cfg = n;
      cfg_count++;
   endtask

   task automatic set_idle(int send_pct, int recv_pct);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, saturation, reversed range
      set_limit(ELEMS);
      add_op(MODE_LOAD, 0, 0, SAT_HI);
      add_op(MODE_LOAD, 1023, 0, SAT_LO);
      add_op(MODE_QUERY, 0, 1023, 0);
      add_op(MODE_QUERY, 0, 0, 0);
      add_op(MODE_QUERY, 5, 3, 0);
      add_op(MODE_INCR, 0, 0, 0);
      add_op(MODE_QUERY, 0, 0, 0);
      add_op(MODE_ADD, 0, 1023, SAT_LO);
      add_op(MODE_QUERY, 0, 1023, 0);
      add_op(MODE_ADD, 0, 1023, SAT_HI);
      add_op(MODE_QUERY, 1023, 1023, 0);
      add_op(MODE_LOAD, 512, 0, -5);
      add_op(MODE_ADD, 500, 600, 7);
      add_op(MODE_QUERY, 510, 520, 0);
      add_op(MODE_INCR, 1023, 0, 0);
      add_op(MODE_QUERY, 1023, 1023, 0);
      add_op(MODE_ADD, 700, 699, 9);
      add_op(MODE_QUERY, 0, 1023, 0);
      drain();

      // receiver held off while the sender keeps going
      set_idle(0, 0);
      hold_req <= 1'b1;
      @(posedge clock);
      hold_req <= 1'b0;
      add_random(250);
      drain();

      set_limit(1);
      set_idle(72, 0);
      add_op(MODE_QUERY, 0, 1023, 0);
      add_op(MODE_LOAD, 1, 0, 3);
      add_random(60);
      drain();

      // limited range: clipping and points past the limit
      set_limit(37);
      set_idle(0, 72);
      add_op(MODE_QUERY, 40, 50, 0);
      add_op(MODE_LOAD, 100, 0, -77);
      add_op(MODE_ADD, 30, 1023, -4);
      add_op(MODE_QUERY, 30, 1023, 0);
      add_random(200);
      drain();

      set_limit(1023);
      set_idle(9, 9);
      add_random(300);
      drain();

      // elements past the old limit come back into view
      set_limit(ELEMS);
      set_idle(72, 72);
      add_op(MODE_QUERY, 0, 1023, 0);
      add_random(150);
      drain();

      set_limit(600);
      set_idle(0, 0);
      add_random(150);
      drain();

      $display("%0d items sent, %0d query results checked, %0d limit settings",
               ops_done, mins_seen, cfg_count);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", errors);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### files.f
rtl/rarmt_pkg.sv
rtl/rarmt_ctrl.sv
rtl/rarmt_dpath.sv
rtl/range_add_range_min_tree_unit.sv
test/range_add_range_min_tree_unit_tb.sv
